[design/fut_pkg.sv]
// Shared types, constants and trailer byte function for the frame trailer tagger.
package fut_pkg;

   localparam int unsigned TAIL_LEN    = 12;
   localparam int unsigned TRAILER_LEN = 16;
   localparam int unsigned CSR_IDX_W   = 8;

   localparam logic [7:0] TAG_HI = 8'h65;
   localparam logic [7:0] TAG_LO = 8'h87;

   localparam logic [CSR_IDX_W-1:0] CSR_MONITOR_ID   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INGRESS_PORT = 8'd1;

   // One accepted input beat after classification.
   typedef struct packed {
      logic [63:0] timestamp;
      logic [7:0]  data;
      logic        last;
      logic        append;
   } entry_type;

   // Big-endian trailer: timestamp, monitor id, port, low timestamp, tag.
   function automatic logic [7:0] trailer_byte(input logic [63:0] ts,
                                               input logic [15:0] mon,
                                               input logic [15:0] port,
                                               input logic [3:0]  idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = ts[63:56];
         4'd1:    b = ts[55:48];
         4'd2:    b = ts[47:40];
         4'd3:    b = ts[39:32];
         4'd4:    b = ts[31:24];
         4'd5:    b = ts[23:16];
         4'd6:    b = ts[15:8];
         4'd7:    b = ts[7:0];
         4'd8:    b = mon[15:8];
         4'd9:    b = mon[7:0];
         4'd10:   b = port[15:8];
         4'd11:   b = port[7:0];
         4'd12:   b = ts[15:8];
         4'd13:   b = ts[7:0];
         4'd14:   b = TAG_HI;
         default: b = TAG_LO;
      endcase
      return b;
   endfunction

endpackage

[design/fut_front.sv]
// Front end: keeps the frame tail and classifies each final byte as tagged or not.
module fut_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_room,
   input  logic [7:0]         in_data,
   input  logic               in_last,
   input  logic [63:0]        in_timestamp,
   output logic               push,
   output fut_pkg::entry_type push_entry
);
   import fut_pkg::*;

   logic [7:0] tail_ff [TAIL_LEN];
   logic [7:0] tail_in [TAIL_LEN];
   logic [3:0] seen_ff, seen_in;
   logic       has_trailer;

   assign push = in_valid && in_room;

   // Compare against the tail as it stands after shifting in this byte.
   assign has_trailer = (seen_ff >= 4'(TAIL_LEN - 1)) &&
                        (tail_ff[11] == TAG_HI) && (in_data == TAG_LO) &&
                        (tail_ff[9] == tail_ff[3]) && (tail_ff[10] == tail_ff[4]);

   always_comb begin
      push_entry.timestamp = in_timestamp;
      push_entry.data      = in_data;
      push_entry.last      = in_last;
      push_entry.append    = in_last && !has_trailer;
   end

   always_comb begin
      tail_in = tail_ff;
      seen_in = seen_ff;
      if (push) begin
         if (in_last) begin
            for (int i = 0; i < TAIL_LEN; i++) tail_in[i] = 8'd0;
            seen_in = 4'd0;
         end else begin
            for (int i = 0; i < TAIL_LEN - 1; i++) tail_in[i] = tail_ff[i+1];
            tail_in[TAIL_LEN-1] = in_data;
            if (seen_ff < 4'(TAIL_LEN)) seen_in = seen_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAIL_LEN; i++) tail_ff[i] <= 8'd0;
         seen_ff <= 4'd0;
      end else begin
         tail_ff <= tail_in;
         seen_ff <= seen_in;
      end
   end

endmodule

[design/fut_queue.sv]
// Short queue of classified beats between the front and back ends.
module fut_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fut_pkg::entry_type       push_entry,
   input  logic                     pop,
   output logic                     room,
   output logic                     nonempty,
   output fut_pkg::entry_type       head,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import fut_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign room     = (count_ff != CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = mem[rd_ptr_ff];
   assign count    = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/fut_back.sv]
// Back end: passes queued bytes out and sequences the 16-byte trailer.
module fut_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_nonempty,
   input  fut_pkg::entry_type q_head,
   output logic               q_pop,
   input  logic [15:0]        monitor_id,
   input  logic [15:0]        ingress_port,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_last,
   output logic               out_appended
);
   import fut_pkg::*;

   typedef enum logic [1:0] {
      ST_PASS  = 2'b01,
      ST_TRAIL = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [63:0] ts_ff, ts_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        app_ff, app_in;
   logic        load;
   logic        final_beat;

   assign load       = !valid_ff || out_ready;
   assign final_beat = (idx_ff == 4'(TRAILER_LEN - 1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ts_in    = ts_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      app_in   = app_ff;
      q_pop    = 1'b0;
      case (state_ff)
         ST_PASS: begin
            if (load) begin
               valid_in = q_nonempty;
               if (q_nonempty) begin
                  q_pop   = 1'b1;
                  byte_in = q_head.data;
                  last_in = q_head.last && !q_head.append;
                  app_in  = 1'b0;
                  if (q_head.append) begin
                     state_in = ST_TRAIL;
                     idx_in   = 4'd0;
                     ts_in    = q_head.timestamp;
                  end
               end
            end
         end
         ST_TRAIL: begin
            if (load) begin
               valid_in = 1'b1;
               byte_in  = trailer_byte(ts_ff, monitor_id, ingress_port, idx_ff);
               last_in  = final_beat;
               app_in   = final_beat;
               idx_in   = idx_ff + 4'd1;
               if (final_beat) state_in = ST_PASS;
            end
         end
         default: begin
            state_in = ST_PASS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PASS;
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff   <= ts_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      app_ff  <= app_in;
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign out_last     = last_ff;
   assign out_appended = app_ff;

endmodule

[design/frame_uid_trailer_tagger_core.sv]
// Top level of the frame trailer tagger: register port, front, queue and back end.
//
// Frame bytes stream through at one beat per clock while req_tready is high. The last
// 12 bytes of each frame are held so that, on the beat marked tlast, the block can
// see whether the frame already ends in a 16-byte ID trailer (last two bytes 0x65
// 0x87, preceded by the low 16 timestamp bits of that trailer). If not, a big-endian
// trailer of timestamp, monitor id, ingress port, low timestamp and 0x6587 follows
// the frame, and rsp_tuser is set on its final beat. An untagged frame end adds 16
// trailer beats to the output, during which the trailer sequencer in the back end
// holds the queue and req_tready drops once the queue is full. Write monitor_id
// (index 0) and ingress_port (index 1) only while no frame is in flight.
module frame_uid_trailer_tagger_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [71:0]                   req_tdata,   // [7:0] data_byte, [71:8] timestamp_ns
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tlast,
   output logic                          rsp_tuser,   // [0] trailer_appended
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fut_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);
   import fut_pkg::*;

   logic [15:0] monitor_id_ff, monitor_id_in;
   logic [15:0] port_ff, port_in;
   logic        q_room, q_nonempty, q_pop, push;
   entry_type   push_entry, q_head;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

   assign csr_ready = 1'b1;

   always_comb begin
      monitor_id_in = monitor_id_ff;
      port_in       = port_ff;
      if (csr_valid) begin
         if (csr_index == CSR_MONITOR_ID)   monitor_id_in = csr_data;
         if (csr_index == CSR_INGRESS_PORT) port_in       = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         monitor_id_ff <= 16'd0;
         port_ff       <= 16'd0;
      end else begin
         monitor_id_ff <= monitor_id_in;
         port_ff       <= port_in;
      end
   end

   assign req_tready = q_room;

   fut_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_room      (q_room),
      .in_data      (req_tdata[7:0]),
      .in_last      (req_tlast),
      .in_timestamp (req_tdata[71:8]),
      .push         (push),
      .push_entry   (push_entry)
   );

   fut_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .room       (q_room),
      .nonempty   (q_nonempty),
      .head       (q_head),
      .count      (q_count)
   );

   fut_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_nonempty   (q_nonempty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .monitor_id   (monitor_id_ff),
      .ingress_port (port_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .out_last     (rsp_tlast),
      .out_appended (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_append_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("trailer flag on a beat that does not end the frame");

   a_append_tag_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == TAG_LO)
      else $error("appended trailer does not end in the tag byte");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nonempty)
      else $error("queue popped while empty");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the frame trailer tagger: byte predictor, idling, back-pressure.
module testbench;
   import fut_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned HOLD_CYCLES  = 120;
   localparam int unsigned SETTLE_TIME  = 40;
   localparam int unsigned PHASE_ITEMS  = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SPARE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_SPARE   = 8'hFF;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       appended;
   } tx_byte_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [71:0]          req_tdata = '0;   // [7:0] data_byte, [71:8] timestamp_ns
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [7:0] out_byte
   logic                 rsp_tlast;
   logic                 rsp_tuser;        // [0] trailer_appended
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_data = '0;

   // Predictor state: sliding frame tail and the two trailer registers.
   logic [7:0]   tail_window [0:TAIL_LEN-1];
   int unsigned  fill_count;
   logic [15:0]  monitor_id_reg;
   logic [15:0]  ingress_port_reg;
   tx_byte_type  expected_bytes [$];

   logic [7:0]   frame_bytes [$];
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   bit           hold_off_start;
   int unsigned  hold_off_left;
   int unsigned  mismatch_count;
   int unsigned  cycle_count;
   int unsigned  bytes_sent;
   int unsigned  frames_sent;
   int unsigned  beats_checked;
   int unsigned  trailers_seen;
   int unsigned  untouched_frames;

   frame_uid_trailer_tagger_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d beats outstanding",
                  expected_bytes.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [127:0] trailer_bits(input logic [63:0] ts,
                                                 input logic [15:0] mon,
                                                 input logic [15:0] port);
      return {ts, mon, port, ts[15:0], TAG_HI, TAG_LO};
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < TAIL_LEN; i++) tail_window[i] = 8'h00;
      fill_count = 0;
   endfunction

   function automatic void push_beat(input logic [7:0] b, input logic l, input logic a);
      tx_byte_type t;
      t.out_byte = b;
      t.out_last = l;
      t.appended = a;
      expected_bytes.push_back(t);
   endfunction

   // Shift the byte in, and on the frame's last byte decide whether to append.
   function automatic void predict_byte(input logic [7:0] b, input logic last,
                                        input logic [63:0] ts);
      logic         has_trailer;
      logic [127:0] tr;
      for (int i = 0; i < TAIL_LEN - 1; i++) tail_window[i] = tail_window[i+1];
      tail_window[TAIL_LEN-1] = b;
      if (fill_count < TAIL_LEN) fill_count++;
      if (!last) begin
         push_beat(b, 1'b0, 1'b0);
         return;
      end
      // window[0] lines up with byte 4 of a candidate trailer
      has_trailer = fill_count >= TAIL_LEN && tail_window[10] == TAG_HI &&
                    tail_window[11] == TAG_LO && tail_window[8] == tail_window[2] &&
                    tail_window[9] == tail_window[3];
      clear_window();
      if (has_trailer) begin
         push_beat(b, 1'b1, 1'b0);
         return;
      end
      push_beat(b, 1'b0, 1'b0);
      tr = trailer_bits(ts, monitor_id_reg, ingress_port_reg);
      for (int i = 0; i < TRAILER_LEN; i++)
         push_beat(tr[127 - 8*i -: 8], i == TRAILER_LEN - 1, i == TRAILER_LEN - 1);
   endfunction

   function automatic void check_beat();
      tx_byte_type e;
      if (expected_bytes.size() == 0) begin
         $error("unexpected beat: out_byte %h out_last %b trailer_appended %b",
                rsp_tdata, rsp_tlast, rsp_tuser);
         mismatch_count++;
         return;
      end
      e = expected_bytes.pop_front();
      beats_checked++;
      if (rsp_tdata !== e.out_byte) begin
         $error("out_byte: expected %h, got %h", e.out_byte, rsp_tdata);
         mismatch_count++;
      end
      if (rsp_tlast !== e.out_last) begin
         $error("out_last: expected %b, got %b", e.out_last, rsp_tlast);
         mismatch_count++;
      end
      if (rsp_tuser !== e.appended) begin
         $error("trailer_appended: expected %b, got %b", e.appended, rsp_tuser);
         mismatch_count++;
      end
      if (e.out_last) begin
         if (e.appended) trailers_seen++;
         else untouched_frames++;
      end
   endfunction

   // Predict before checking so a same-edge pass-through cannot race.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_byte(req_tdata[7:0], req_tlast, req_tdata[71:8]);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MONITOR_ID) monitor_id_reg = csr_data;
            else if (csr_index == CSR_INGRESS_PORT) ingress_port_reg = csr_data;
         end
         if (rsp_tvalid && rsp_tready) check_beat();
      end
      if (hold_off_start) begin
         hold_off_left = HOLD_CYCLES;
         hold_off_start = 1'b0;
      end
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last, input logic [63:0] ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ts, b};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send frame_bytes as one frame; only the last beat's timestamp matters.
   task automatic send_frame(input logic [63:0] ts);
      int unsigned n;
      n = frame_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(frame_bytes[i], i == n - 1, (i == n - 1) ? ts : {$urandom, $urandom});
      frames_sent++;
   endtask

   function automatic void load_trailer(input logic [63:0] ts, input logic [15:0] mon,
                                        input logic [15:0] port, input int unsigned first);
      logic [127:0] tr;
      tr = trailer_bits(ts, mon, port);
      for (int i = first; i < TRAILER_LEN; i++) frame_bytes.push_back(tr[127 - 8*i -: 8]);
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high; configure() lowers it after the batch.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] mon, input logic [15:0] port);
      write_csr(CSR_MONITOR_ID, mon);
      write_csr(CSR_INGRESS_PORT, port);
      // out-of-range indexes must leave both registers alone
      write_csr(($urandom_range(1) != 0) ? CSR_FIRST_SPARE : CSR_TOP_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic test_directed();
      // single-byte frame on reset register values, all-ones fields
      frame_bytes = '{8'hFF};
      send_frame(64'hFFFF_FFFF_FFFF_FFFF);
      drain();
      configure(16'hFFFF, 16'h0000);
      // exactly 12 bytes shaped as a trailer tail: counts as tagged
      frame_bytes.delete();
      load_trailer(64'h0, 16'h0000, 16'h0000, 4);
      send_frame(64'h0);
      // 11 bytes of the same shape: short frame, gets a trailer
      frame_bytes.delete();
      load_trailer({$urandom, $urandom}, 16'($urandom), 16'($urandom), 5);
      send_frame({$urandom, $urandom});
      drain();
   endtask

   task automatic build_random_frame();
      int unsigned  sel;
      int unsigned  len;
      int unsigned  pos;
      sel = $urandom_range(9);
      frame_bytes.delete();
      if (sel < 2) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
         repeat (len) frame_bytes.push_back(8'($urandom));
      end else if (sel == 9) begin
         load_trailer({$urandom, $urandom}, 16'($urandom), 16'($urandom),
                      $urandom_range(5, 15));
      end else begin
         repeat ($urandom_range(0, 8)) frame_bytes.push_back(8'($urandom));
         load_trailer({$urandom, $urandom}, 16'($urandom), 16'($urandom), 0);
         if (sel >= 7) begin
            // break the tag, the low timestamp or its copy by one bit
            case ($urandom_range(5))
               0: pos = 6;
               1: pos = 7;
               2: pos = 12;
               3: pos = 13;
               4: pos = 14;
               default: pos = 15;
            endcase
            pos = frame_bytes.size() - TRAILER_LEN + pos;
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
         end
      end
   endtask

   task automatic run_traffic(input logic [15:0] mon, input logic [15:0] port);
      int unsigned start_count;
      logic [63:0] ts;
      drain();
      configure(mon, port);
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_ITEMS) begin
         build_random_frame();
         case ($urandom_range(7))
            0:       ts = 64'h0;
            1:       ts = 64'hFFFF_FFFF_FFFF_FFFF;
            default: ts = {$urandom, $urandom};
         endcase
         send_frame(ts);
      end
   endtask

   task automatic test_random_traffic();
      set_idle(22, 65);
      run_traffic(16'($urandom), 16'($urandom));
      set_idle(65, 22);
      run_traffic(16'h0000, 16'hFFFF);
      set_idle(0, 0);
      run_traffic(16'($urandom), 16'($urandom));
      drain();
   endtask

   // Stall the output while short frames keep arriving so the input backs up.
   task automatic test_output_backpressure();
      set_idle(0, 0);
      configure(16'($urandom), 16'($urandom));
      hold_off_start = 1'b1;
      repeat (6) begin
         frame_bytes = '{8'($urandom), 8'($urandom)};
         send_frame({$urandom, $urandom});
      end
      drain();
   endtask

   initial begin
      clear_window();
      monitor_id_reg   = '0;
      ingress_port_reg = '0;
      hold_off_start   = 1'b0;
      hold_off_left    = 0;
      set_idle(0, 0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic();
      test_output_backpressure();
      repeat (SETTLE_TIME) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected beats never arrived", expected_bytes.size());
         mismatch_count++;
      end
      $display("Sent %0d frames (%0d bytes) under three idle mixes and one long output stall",
               frames_sent, bytes_sent);
      $display("Checked %0d beats: %0d trailers appended, %0d frames passed unchanged",
               beats_checked, trailers_seen, untouched_frames);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
design/fut_pkg.sv
design/fut_front.sv
design/fut_queue.sv
design/fut_back.sv
design/frame_uid_trailer_tagger_core.sv
dv/testbench.sv
